/* rtl/lef_pkg.sv */
package lef_pkg;

  localparam int LINE_CHARS_DEF  = 80;
  localparam int FIELD_LIMIT_DEF = 5;

  localparam logic [7:0] CODE_BS    = 8'd8;
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] CODE_SPACE = 8'd32;
  localparam logic [7:0] CODE_ZERO  = 8'd48;
  localparam logic [7:0] CODE_NINE  = 8'd57;
  localparam logic [7:0] CODE_UC_A  = 8'd65;
  localparam logic [7:0] CODE_UC_Z  = 8'd90;
  localparam logic [7:0] CODE_LC_A  = 8'd97;
  localparam logic [7:0] CODE_LC_Z  = 8'd122;
  localparam logic [7:0] CODE_DEL   = 8'd127;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH,
    ST_LOAD,
    ST_SHOW
  } state_t;

  typedef enum logic [1:0] {
    CLS_DELIM,
    CLS_ALPHA,
    CLS_DIGIT
  } cls_t;

  typedef struct packed {
    logic        digit;
    logic [6:0]  start;
    logic [6:0]  length;
    logic [31:0] value;
    logic        ovf;
  } rec_t;

  function automatic cls_t char_class(input logic [7:0] b);
    cls_t c;
    c = CLS_DELIM;
    if ((b >= CODE_UC_A && b <= CODE_UC_Z) || (b >= CODE_LC_A && b <= CODE_LC_Z)) begin
      c = CLS_ALPHA;
    end else if (b >= CODE_ZERO && b <= CODE_NINE) begin
      c = CLS_DIGIT;
    end
    return c;
  endfunction

endpackage

/* rtl/line_editor_field_tokenizer.sv */
// A byte that does not end a line is accepted while idle, and the block stays ready for the next.
// A line end scans the line store one character at a time (read, then evaluate), stopping
// early at the field limit, then goes through flush and load to the first result.
// Each result is loaded from record memory, then shown until out_ready takes it; no byte is taken meanwhile.
// Reset clears the state machine, the character count and the field count; line and
// record memories hold whatever they held and are only read where written this line.
module line_editor_field_tokenizer #(
  parameter int LINE_CHARS  = lef_pkg::LINE_CHARS_DEF,
  parameter int FIELD_LIMIT = lef_pkg::FIELD_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_field_index,
  output logic        out_field_kind,
  output logic [6:0]  out_field_start,
  output logic [6:0]  out_field_length,
  output logic [31:0] out_field_value,
  output logic        out_value_overflow,
  output logic [2:0]  out_field_total,
  output logic        out_last_field
);

  localparam int CW  = $clog2(LINE_CHARS + 1);
  localparam int AW  = $clog2(LINE_CHARS);
  localparam int FW  = $clog2(FIELD_LIMIT + 1);
  localparam int FIW = (FIELD_LIMIT > 1) ? $clog2(FIELD_LIMIT) : 1;

  lef_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]  char_count_r;
  logic [CW-1:0]  pos_r;
  logic [FW-1:0]  found_r;
  logic [FIW-1:0] emit_idx_r;
  logic           run_active_r;
  logic           run_digit_r;
  logic [CW-1:0]  run_start_r;
  logic [CW-1:0]  run_len_r;
  logic [31:0]    run_val_r;
  logic           run_ovf_r;

  logic [7:0]     line_mem [LINE_CHARS];
  logic [7:0]     line_rd_r;
  lef_pkg::rec_t  rec_mem [FIELD_LIMIT];
  lef_pkg::rec_t  rec_rd_r;
  lef_pkg::rec_t  rec_wdata;
  logic [FIW-1:0] rec_waddr;

  logic           in_acc, out_acc;
  logic           is_erase, is_cr, is_store, line_done;
  logic [CW-1:0]  count_inc;
  logic           line_we, rec_we;

  lef_pkg::cls_t  cls;
  logic           is_dig, extend, new_run, limit_hit, scan_last;
  logic [35:0]    acc_sum;
  logic           last_out, has_fields;

  // Input decode
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign is_erase  = (in_rx_byte == lef_pkg::CODE_BS || in_rx_byte == lef_pkg::CODE_DEL)
                     && (char_count_r != '0);
  assign is_cr     = (in_rx_byte == lef_pkg::CODE_CR);
  assign is_store  = !is_erase && !is_cr && (in_rx_byte >= lef_pkg::CODE_SPACE);
  assign count_inc = char_count_r + CW'(1);
  assign line_done = is_cr || (is_store && count_inc == CW'(LINE_CHARS));

  // Scan decode
  assign cls       = lef_pkg::char_class(line_rd_r);
  assign is_dig    = (cls == lef_pkg::CLS_DIGIT);
  assign extend    = run_active_r && (cls != lef_pkg::CLS_DELIM) && (is_dig == run_digit_r);
  assign new_run   = !extend && (cls != lef_pkg::CLS_DELIM);
  assign limit_hit = new_run && (found_r == FW'(FIELD_LIMIT));
  assign scan_last = (pos_r + CW'(1)) == char_count_r;
  assign acc_sum   = {1'b0, run_val_r, 3'b000} + {3'b000, run_val_r, 1'b0}
                     + {32'd0, line_rd_r[3:0]};

  assign rec_waddr        = FIW'(found_r - FW'(1));
  assign rec_wdata.digit  = run_digit_r;
  assign rec_wdata.start  = 7'(run_start_r);
  assign rec_wdata.length = 7'(run_len_r);
  assign rec_wdata.value  = run_val_r;
  assign rec_wdata.ovf    = run_ovf_r;

  assign has_fields = (found_r != '0);
  assign last_out   = !has_fields || ((FW'(emit_idx_r) + FW'(1)) == found_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lef_pkg::ST_IDLE: begin
        if (in_acc && line_done) begin
          state_nxt = (is_cr && char_count_r == '0) ? lef_pkg::ST_FLUSH : lef_pkg::ST_READ;
        end
      end
      lef_pkg::ST_READ: state_nxt = lef_pkg::ST_EVAL;
      lef_pkg::ST_EVAL: begin
        if (limit_hit || scan_last) begin
          state_nxt = lef_pkg::ST_FLUSH;
        end else begin
          state_nxt = lef_pkg::ST_READ;
        end
      end
      lef_pkg::ST_FLUSH: state_nxt = lef_pkg::ST_LOAD;
      lef_pkg::ST_LOAD:  state_nxt = lef_pkg::ST_SHOW;
      lef_pkg::ST_SHOW: begin
        if (out_acc) begin
          state_nxt = last_out ? lef_pkg::ST_IDLE : lef_pkg::ST_LOAD;
        end
      end
      default: state_nxt = lef_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == lef_pkg::ST_IDLE);
    out_valid = (state_r == lef_pkg::ST_SHOW);
    line_we   = in_acc && is_store;
    rec_we    = run_active_r && (((state_r == lef_pkg::ST_EVAL) && !extend)
                                 || (state_r == lef_pkg::ST_FLUSH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lef_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r <= '0;
      pos_r        <= '0;
      found_r      <= '0;
      emit_idx_r   <= '0;
      run_active_r <= 1'b0;
    end else begin
      unique case (state_r)
        lef_pkg::ST_IDLE: begin
          pos_r        <= '0;
          found_r      <= '0;
          emit_idx_r   <= '0;
          run_active_r <= 1'b0;
          if (in_acc && is_erase) begin
            char_count_r <= char_count_r - CW'(1);
          end else if (in_acc && is_store) begin
            char_count_r <= count_inc;
          end
        end
        lef_pkg::ST_EVAL: begin
          pos_r <= pos_r + CW'(1);
          if (extend) begin
            run_len_r <= run_len_r + CW'(1);
            if (run_digit_r) begin
              run_val_r <= acc_sum[31:0];
              run_ovf_r <= run_ovf_r | (|acc_sum[35:32]);
            end
          end else if (new_run && !limit_hit) begin
            run_active_r <= 1'b1;
            run_digit_r  <= is_dig;
            run_start_r  <= pos_r;
            run_len_r    <= CW'(1);
            run_val_r    <= is_dig ? {28'd0, line_rd_r[3:0]} : 32'd0;
            run_ovf_r    <= 1'b0;
            found_r      <= found_r + FW'(1);
          end else begin
            // delimiter or field limit: the run just closed is already written
            run_active_r <= 1'b0;
          end
        end
        lef_pkg::ST_FLUSH: run_active_r <= 1'b0;
        lef_pkg::ST_SHOW: begin
          if (out_acc) begin
            if (last_out) begin
              char_count_r <= '0;
            end else begin
              emit_idx_r <= emit_idx_r + FIW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Line store: written while collecting, read once per scanned position
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[char_count_r[AW-1:0]] <= in_rx_byte;
    end
    line_rd_r <= line_mem[pos_r[AW-1:0]];
  end

  // Field records: written as each run closes, read back for the result transfers
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rd_r <= rec_mem[emit_idx_r];
  end

  assign out_field_index    = 3'(emit_idx_r);
  assign out_field_kind     = has_fields & rec_rd_r.digit;
  assign out_field_start    = has_fields ? rec_rd_r.start : 7'd0;
  assign out_field_length   = has_fields ? rec_rd_r.length : 7'd0;
  assign out_field_value    = has_fields ? rec_rd_r.value : 32'd0;
  assign out_value_overflow = has_fields & rec_rd_r.ovf;
  assign out_field_total    = 3'(found_r);
  assign out_last_field     = last_out;

  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    found_r <= FW'(FIELD_LIMIT))
    else $error("field count beyond limit");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    char_count_r <= CW'(LINE_CHARS))
    else $error("character count beyond line length");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lef_pkg::ST_SHOW && has_fields) |-> (FW'(emit_idx_r) < found_r))
    else $error("result index beyond field count");

  a_rec_write: assert property (@(posedge clk) disable iff (!rst_n)
    rec_we |-> has_fields)
    else $error("record write with no field open");

  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_field) |=> (char_count_r == '0 && in_ready))
    else $error("line not cleared after final result");

endmodule

/* tb/tb_top.sv */
module tb_top;
  import lef_pkg::*;

  localparam int LINE_CHARS       = LINE_CHARS_DEF;
  localparam int FIELD_LIMIT      = FIELD_LIMIT_DEF;
  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 7;
  localparam int CYCLE_LIMIT      = 500000;
  localparam int SETTLE_CYCLES    = 2 * LINE_CHARS + 40;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int GAP_PERCENT      = 13;
  localparam int MAX_REPORTS      = 40;
  localparam int RANDOM_ITEMS     = 170;
  localparam int BURST_ITEMS      = 60;

  localparam logic [7:0] CODE_NUL     = 8'd0;
  localparam logic [7:0] CODE_US      = 8'd31;
  localparam logic [7:0] CODE_BANG    = 8'd33;
  localparam logic [7:0] CODE_SLASH   = 8'd47;
  localparam logic [7:0] CODE_COLON   = 8'd58;
  localparam logic [7:0] CODE_AT      = 8'd64;
  localparam logic [7:0] CODE_TILDE   = 8'd126;
  localparam logic [7:0] CODE_HIGH_LO = 8'd128;
  localparam logic [7:0] CODE_HIGH_HI = 8'd255;

  typedef struct packed {
    logic [2:0]  index;
    logic        kind;
    logic [6:0]  start;
    logic [6:0]  length;
    logic [31:0] value;
    logic        ovf;
    logic [2:0]  total;
    logic        last;
  } field_rec_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_field_index;
  logic        out_field_kind;
  logic [6:0]  out_field_start;
  logic [6:0]  out_field_length;
  logic [31:0] out_field_value;
  logic        out_value_overflow;
  logic [2:0]  out_field_total;
  logic        out_last_field;

  // predictor state: the line as the block should hold it
  logic [7:0]  line_buf [LINE_CHARS];
  int          line_len;
  field_rec_t  pending_fields [$];

  int          mismatch_count = 0;
  int          items_sent;
  int unsigned cycle_count = 0;
  bit          tx_gaps_on;
  bit          rx_stalls_on;
  int          hold_cycles;
  logic        hold_active;
  bit          hold_done;

  line_editor_field_tokenizer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_field_index    (out_field_index),
    .out_field_kind     (out_field_kind),
    .out_field_start    (out_field_start),
    .out_field_length   (out_field_length),
    .out_field_value    (out_field_value),
    .out_value_overflow (out_value_overflow),
    .out_field_total    (out_field_total),
    .out_last_field     (out_last_field)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_fields.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic cls_t code_class(input logic [7:0] c);
    cls_t cls;
    cls = CLS_DELIM;
    if (c >= CODE_ZERO && c <= CODE_NINE) cls = CLS_DIGIT;
    if ((c >= CODE_UC_A && c <= CODE_UC_Z) || (c >= CODE_LC_A && c <= CODE_LC_Z)) cls = CLS_ALPHA;
    return cls;
  endfunction

  // scan the finished line and queue one record per field, or one empty last record if there are none
  function automatic void tokenize_line();
    int         starts [FIELD_LIMIT];
    cls_t       kinds  [FIELD_LIMIT];
    int         found;
    int         pos;
    int         k;
    cls_t       prev;
    cls_t       cur;
    logic [63:0] acc;
    logic       ovf;
    int         run;
    field_rec_t rec;
    found = 0;
    prev  = CLS_DELIM;
    for (pos = 0; pos < line_len && found < FIELD_LIMIT; pos++) begin
      cur = code_class(line_buf[pos]);
      if (cur != CLS_DELIM && cur != prev) begin
        starts[found] = pos;
        kinds[found]  = cur;
        found++;
      end
      prev = cur;
    end
    if (found == 0) begin
      rec      = '0;
      rec.last = 1'b1;
      pending_fields.push_back(rec);
    end
    for (k = 0; k < found; k++) begin
      acc = '0;
      ovf = 1'b0;
      run = 0;
      pos = starts[k];
      // the run extends past the field limit but never past the line end
      while (pos < line_len && code_class(line_buf[pos]) == kinds[k]) begin
        if (kinds[k] == CLS_DIGIT) begin
          acc = acc * 10 + (line_buf[pos] - CODE_ZERO);
          if (acc > 64'hFFFF_FFFF) begin
            ovf = 1'b1;
            acc = acc & 64'hFFFF_FFFF;
          end
        end
        run++;
        pos++;
      end
      rec.index  = k[2:0];
      rec.kind   = (kinds[k] == CLS_DIGIT);
      rec.start  = starts[k][6:0];
      rec.length = run[6:0];
      rec.value  = acc[31:0];
      rec.ovf    = ovf;
      rec.total  = found[2:0];
      rec.last   = (k + 1 == found);
      pending_fields.push_back(rec);
    end
    line_len = 0;
  endfunction

  function automatic void apply_byte(input logic [7:0] code);
    if ((code == CODE_BS || code == CODE_DEL) && line_len > 0) begin
      line_len--;
    end else if (code == CODE_CR) begin
      tokenize_line();
    end else if (code >= CODE_SPACE) begin
      if (line_len < LINE_CHARS) begin
        line_buf[line_len] = code;
        line_len++;
      end
      if (line_len >= LINE_CHARS) tokenize_line();
    end
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_field();
    field_rec_t seen;
    field_rec_t want;
    seen = '{out_field_index, out_field_kind, out_field_start, out_field_length,
             out_field_value, out_value_overflow, out_field_total, out_last_field};
    if (pending_fields.size() == 0) begin
      report_mismatch("result with nothing expected, field_index", seen.index, 0);
    end else begin
      want = pending_fields.pop_front();
      if (seen.index  !== want.index)  report_mismatch("field_index", seen.index, want.index);
      if (seen.kind   !== want.kind)   report_mismatch("field_kind", seen.kind, want.kind);
      if (seen.start  !== want.start)  report_mismatch("field_start", seen.start, want.start);
      if (seen.length !== want.length) report_mismatch("field_length", seen.length, want.length);
      if (seen.value  !== want.value)  report_mismatch("field_value", seen.value, want.value);
      if (seen.ovf    !== want.ovf)    report_mismatch("value_overflow", seen.ovf, want.ovf);
      if (seen.total  !== want.total)  report_mismatch("field_total", seen.total, want.total);
      if (seen.last   !== want.last)   report_mismatch("last_field", seen.last, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_field();
    out_ready <= !hold_active && !(rx_stalls_on && $urandom_range(0, 99) < GAP_PERCENT);
  end

  // hold the result side off for a counted stretch when asked
  initial begin
    hold_active = 1'b0;
    hold_done   = 1'b0;
    forever begin
      wait (hold_cycles > 0);
      hold_done = 1'b0;
      @(posedge clk);
      hold_active <= 1'b1;
      repeat (hold_cycles) @(posedge clk);
      hold_active <= 1'b0;
      hold_done = 1'b1;
      wait (hold_cycles == 0);
    end
  end

  task automatic send_byte(input logic [7:0] code);
    while (tx_gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    apply_byte(code);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_fields();
    pause_sender();
    while (pending_fields.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(input int n);
    repeat (n) begin
      if ($urandom_range(0, 1)) send_byte(8'(CODE_UC_A + $urandom_range(0, 25)));
      else send_byte(8'(CODE_LC_A + $urandom_range(0, 25)));
    end
  endtask

  task automatic send_number(input int n);
    repeat (n) send_byte(8'(CODE_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic send_delimiter();
    case ($urandom_range(0, 3))
      0: send_byte(CODE_SPACE);
      1: send_byte(8'($urandom_range(CODE_BANG, CODE_SLASH)));
      2: send_byte(8'($urandom_range(CODE_COLON, CODE_AT)));
      default: send_byte(8'($urandom_range(CODE_HIGH_LO, CODE_HIGH_HI)));
    endcase
  endtask

  // a line of words and numbers with the odd edit or stray control code
  task automatic send_random_line();
    int target;
    int roll;
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, LINE_CHARS - 1)
                                         : $urandom_range(0, 16);
    while (line_len < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) send_word($urandom_range(1, 8));
      else if (roll < 65) send_number($urandom_range(1, 12));
      else if (roll < 85) send_delimiter();
      else if (roll < 93) send_byte($urandom_range(0, 1) ? CODE_BS : CODE_DEL);
      else send_byte(8'($urandom_range(CODE_NUL, CODE_US)));
    end
    if ($urandom_range(0, 99) < 85) begin
      send_byte(CODE_CR);
    end else begin
      // fill up until the line closes on its own
      do send_byte(8'($urandom_range(CODE_SPACE, CODE_TILDE))); while (line_len != 0);
    end
  endtask

  task automatic test_line_editing();
    send_byte(CODE_CR);
    send_byte(CODE_BS);
    send_byte(CODE_NUL);
    send_byte(CODE_US);
    send_byte(CODE_DEL);
    send_byte(CODE_HIGH_HI);
    send_byte(CODE_HIGH_LO);
    send_text("Zaz@[`{09/:A");
    send_byte(CODE_BS);
    send_byte(CODE_DEL);
    send_byte(CODE_CR);
    wait_for_fields();
  endtask

  task automatic test_digit_overflow();
    send_text("4294967295 4294967296");
    send_byte(CODE_CR);
    wait_for_fields();
  endtask

  task automatic test_field_limit();
    send_text("a1b2cdef");
    send_byte(CODE_CR);
    send_text("a b c d 99999999999");
    send_byte(CODE_CR);
    wait_for_fields();
  endtask

  task automatic test_full_line();
    send_number(LINE_CHARS);
    repeat (LINE_CHARS) begin
      case ($urandom_range(0, 2))
        0: send_byte(8'(CODE_LC_A + $urandom_range(0, 25)));
        1: send_byte(8'(CODE_ZERO + $urandom_range(0, 9)));
        default: send_byte(CODE_SPACE);
      endcase
    end
    wait_for_fields();
  endtask

  task automatic test_output_hold_off();
    hold_cycles = HOLD_OFF_CYCLES;
    send_text("ab 12 cd 34 ef");
    send_byte(CODE_CR);
    send_text("xyz 7");
    send_byte(CODE_CR);
    send_text("q9 r8");
    send_byte(CODE_CR);
    pause_sender();
    wait (hold_done);
    hold_cycles = 0;
    wait_for_fields();
  endtask

  task automatic test_back_to_back();
    int target;
    target       = items_sent + BURST_ITEMS;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    while (items_sent < target) send_random_line();
    wait_for_fields();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_random_lines();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_random_line();
      end
    end
    wait_for_fields();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rx_byte     = '0;
    line_len       = 0;
    items_sent     = 0;
    hold_cycles    = 0;
    tx_gaps_on     = 1'b1;
    rx_stalls_on   = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_line_editing();
    test_digit_overflow();
    test_field_limit();
    test_full_line();
    test_output_hold_off();
    test_back_to_back();
    test_random_lines();

    wait_for_fields();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
